@@ hw/rtl/csa_pkg.sv @@
// Shared types and codes for the checked signed ALU.
// No dependencies; compiled first.
`default_nettype none

package csa_pkg;

	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_SUB   = 5'd1,
		OP_MUL   = 5'd2,
		OP_DIV   = 5'd3,
		OP_MOD   = 5'd4,
		OP_SHL   = 5'd5,
		OP_SHR   = 5'd6,
		OP_LT    = 5'd7,
		OP_LE    = 5'd8,
		OP_GT    = 5'd9,
		OP_GE    = 5'd10,
		OP_EQ    = 5'd11,
		OP_NE    = 5'd12,
		OP_AND   = 5'd13,
		OP_XOR   = 5'd14,
		OP_OR    = 5'd15,
		OP_LAND  = 5'd16,
		OP_LOR   = 5'd17,
		OP_COMMA = 5'd18
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_RANGE  = 2'd1,
		ST_SYNTAX = 2'd2
	} status_t;

	// What the cell chain does with a request.
	typedef enum logic [1:0] {
		K_PASS = 2'd0,
		K_MUL  = 2'd1,
		K_DIV  = 2'd2,
		K_MOD  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t   kind;
		logic    neg;    // negate the magnitude result at the end
		logic    ovf;    // sticky multiply overflow
		status_t status; // error found before the chain
	} ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/csa_if.sv @@
// Request and response channel interfaces for the checked signed ALU.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface csa_req_if;
	logic        valid;
	logic        ready;
	logic [4:0]  action;
	logic signed [63:0] left_operand;
	logic signed [63:0] right_operand;

	modport source (output valid, action, left_operand, right_operand, input ready);
	modport sink   (input valid, action, left_operand, right_operand, output ready);
endinterface

interface csa_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [63:0] value;
	logic [1:0]  status;

	modport source (output valid, value, status, input ready);
	modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/csa_prep.sv @@
// Front stage: operand reduction, the operators that need no chain, and chain setup.
// Uses csa_pkg.
`default_nettype none

module csa_prep import csa_pkg::*; #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         valid_in,
	input  wire logic [4:0]   action,
	input  wire logic [63:0]  left_operand,
	input  wire logic [63:0]  right_operand,
	output logic              valid_s1,
	output ctl_t              ctl_s1,
	output logic [W-1:0]      acc_s1,
	output logic [W-1:0]      q_s1,
	output logic [W-1:0]      mb_s1
);

	localparam int SW = $clog2(W);

	logic [W-1:0] a, b, ma, mb, sum, dif, maxpos, minneg, r;
	logic [SW-1:0] s;
	logic amt_ok, lt_ab, lt_ba;
	ctl_t ctl;
	logic [W-1:0] acc_d, q_d, mb_d;

	always_comb begin
		a      = left_operand[W-1:0];
		b      = right_operand[W-1:0];
		ma     = a[W-1] ? W'(-a) : a;
		mb     = b[W-1] ? W'(-b) : b;
		sum    = a + b;
		dif    = a - b;
		maxpos = {1'b0, {(W-1){1'b1}}};
		minneg = {1'b1, {(W-1){1'b0}}};
		s      = b[SW-1:0];
		amt_ok = !b[W-1] && (b < W'(W));
		lt_ab  = $signed(a) < $signed(b);
		lt_ba  = $signed(b) < $signed(a);
		r      = '0;
		ctl    = '{kind: K_PASS, neg: 1'b0, ovf: 1'b0, status: ST_OK};
		q_d    = ma;
		mb_d   = mb;
		case (op_t'(action))
			OP_ADD: begin
				r = sum;
				if (((a ^ sum) & (b ^ sum)) >> (W-1) != '0) ctl.status = ST_RANGE;
			end
			OP_SUB: begin
				r = dif;
				if (((a ^ b) & (a ^ dif)) >> (W-1) != '0) ctl.status = ST_RANGE;
			end
			OP_MUL: begin
				ctl.kind = K_MUL;
				ctl.neg  = a[W-1] ^ b[W-1];
			end
			OP_DIV, OP_MOD: begin
				ctl.kind = (op_t'(action) == OP_DIV) ? K_DIV : K_MOD;
				ctl.neg  = (op_t'(action) == OP_DIV) ? (a[W-1] ^ b[W-1]) : a[W-1];
				if (b == '0 || (a == minneg && b == '1)) ctl.status = ST_RANGE;
			end
			OP_SHL: begin
				if (!amt_ok || a[W-1] || a > (maxpos >> s)) ctl.status = ST_RANGE;
				else r = a << s;
			end
			OP_SHR: begin
				if (!amt_ok) ctl.status = ST_RANGE;
				else r = W'($signed(a) >>> s);
			end
			OP_LT:    r = W'(lt_ab);
			OP_LE:    r = W'(!lt_ba);
			OP_GT:    r = W'(lt_ba);
			OP_GE:    r = W'(!lt_ab);
			OP_EQ:    r = W'(a == b);
			OP_NE:    r = W'(a != b);
			OP_AND:   r = a & b;
			OP_XOR:   r = a ^ b;
			OP_OR:    r = a | b;
			OP_LAND:  r = W'(a != '0 && b != '0);
			OP_LOR:   r = W'(a != '0 || b != '0);
			OP_COMMA: r = b;
			default:  ctl.status = ST_SYNTAX;
		endcase
		// pass ops carry their result in the accumulator
		acc_d = (ctl.kind == K_PASS) ? r : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			acc_s1 <= acc_d;
			q_s1   <= q_d;
			mb_s1  <= mb_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/csa_cell.sv @@
// One cell of the chain: one restoring-divide or shift-add-multiply step; pass requests go through unchanged.
// Uses csa_pkg.
`default_nettype none

module csa_cell import csa_pkg::*; #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         valid_in,
	input  wire ctl_t         ctl_in,
	input  wire logic [W-1:0] acc_in,
	input  wire logic [W-1:0] q_in,
	input  wire logic [W-1:0] mb_in,
	output logic              valid_q,
	output ctl_t              ctl_q,
	output logic [W-1:0]      acc_q,
	output logic [W-1:0]      q_q,
	output logic [W-1:0]      mb_q
);

	logic         msb, ge;
	logic [W-1:0] sh, acc_d, q_d;
	logic [W:0]   msum;
	ctl_t         ctl_d;

	always_comb begin
		msb   = q_in[W-1];
		sh    = {acc_in[W-2:0], msb};
		ge    = sh >= mb_in;
		msum  = {acc_in, 1'b0} + (msb ? {1'b0, mb_in} : '0);
		ctl_d = ctl_in;
		acc_d = acc_in;
		q_d   = q_in;
		case (ctl_in.kind)
			K_DIV, K_MOD: begin
				acc_d = ge ? sh - mb_in : sh;
				q_d   = {q_in[W-2:0], ge};
			end
			K_MUL: begin
				acc_d     = msum[W-1:0];
				q_d       = {q_in[W-2:0], 1'b0};
				ctl_d.ovf = ctl_in.ovf | acc_in[W-1] | msum[W];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q <= ctl_d;
			acc_q <= acc_d;
			q_q   <= q_d;
			mb_q  <= mb_in;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/csa_post.sv @@
// Back stage: sign fix-up, multiply range check, output register.
// Uses csa_pkg.
`default_nettype none

module csa_post import csa_pkg::*; #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         valid_in,
	input  wire ctl_t         ctl_in,
	input  wire logic [W-1:0] acc_in,
	input  wire logic [W-1:0] q_in,
	output logic              valid_q,
	output logic [63:0]       value_q,
	output logic [1:0]        status_q
);

	logic [W-1:0] mag, r, limit;
	status_t      st;

	always_comb begin
		limit = ctl_in.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		st    = ctl_in.status;
		mag   = (ctl_in.kind == K_DIV) ? q_in : acc_in;
		if (ctl_in.kind == K_MUL && (ctl_in.ovf || acc_in > limit)) st = ST_RANGE;
		r = (ctl_in.kind != K_PASS && ctl_in.neg) ? W'(-mag) : mag;
		if (st != ST_OK) r = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_q  <= 64'($signed(r));
			status_q <= st;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/checked_signed_alu.sv @@
// Checked signed ALU: one request per cycle while no response is stalled.
// A front stage reduces the operands to W bits, resolves every operator that
// needs no chain and sets up multiply/divide/modulo; a chain of W identical cells
// then performs one shift-add (multiply) or restoring-divide step each, one
// operand bit per cell; the back stage applies signs, range-checks the
// product and registers the response. The whole pipe advances whenever the
// output register is empty or being taken, so req.ready drops only while a
// response is stalled. Errors give value 0; status 1 is a range error
// (overflow, divide by zero, MIN/-1, bad shift), status 2 an unknown action.
// Depends on csa_pkg, csa_if, csa_prep, csa_cell, csa_post.
`default_nettype none

module checked_signed_alu import csa_pkg::*; #(
	parameter int WIDTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	csa_req_if.sink    req,
	csa_rsp_if.source  rsp
);

	logic adv;

	logic             valid_c [WIDTH+1];
	ctl_t             ctl_c   [WIDTH+1];
	logic [WIDTH-1:0] acc_c   [WIDTH+1];
	logic [WIDTH-1:0] q_c     [WIDTH+1];
	logic [WIDTH-1:0] mb_c    [WIDTH+1];

	// global stall: move only when the response slot frees up
	assign adv       = !rsp.valid || rsp.ready;
	assign req.ready = adv;

	csa_prep #(.W(WIDTH)) u_prep (
		.clk, .arst_n, .en(adv),
		.valid_in      (req.valid),
		.action        (req.action),
		.left_operand  (req.left_operand),
		.right_operand (req.right_operand),
		.valid_s1      (valid_c[0]),
		.ctl_s1        (ctl_c[0]),
		.acc_s1        (acc_c[0]),
		.q_s1          (q_c[0]),
		.mb_s1         (mb_c[0])
	);

	// one cell per operand bit, MSB first
	for (genvar i = 0; i < WIDTH; i++) begin : g_cell
		csa_cell #(.W(WIDTH)) u_cell (
			.clk, .arst_n, .en(adv),
			.valid_in (valid_c[i]),
			.ctl_in   (ctl_c[i]),
			.acc_in   (acc_c[i]),
			.q_in     (q_c[i]),
			.mb_in    (mb_c[i]),
			.valid_q  (valid_c[i+1]),
			.ctl_q    (ctl_c[i+1]),
			.acc_q    (acc_c[i+1]),
			.q_q      (q_c[i+1]),
			.mb_q     (mb_c[i+1])
		);
	end

	csa_post #(.W(WIDTH)) u_post (
		.clk, .arst_n, .en(adv),
		.valid_in (valid_c[WIDTH]),
		.ctl_in   (ctl_c[WIDTH]),
		.acc_in   (acc_c[WIDTH]),
		.q_in     (q_c[WIDTH]),
		.valid_q  (rsp.valid),
		.value_q  (rsp.value),
		.status_q (rsp.status)
	);

	// divisor register of the last cell feeds nothing further
	logic unused_mb;
	assign unused_mb = ^mb_c[WIDTH];

endmodule

`default_nettype wire

@@ hw/rtl/csa_checker.sv @@
// Port-level checks for checked_signed_alu, bound to the top level.
// Uses csa_pkg codes.
`default_nettype none

module csa_checker import csa_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] rsp_value,
	input wire logic [1:0]  rsp_status
);

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_value == 64'd0)
		else $error("error response with nonzero value");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty output");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value)
			&& $stable(rsp_status))
		else $error("stalled response changed");

endmodule

bind checked_signed_alu csa_checker u_csa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_value  (rsp.value),
	.rsp_status (rsp.status)
);

`default_nettype wire

@@ sim/checked_signed_alu_test.sv @@
// Self-checking bench for checked_signed_alu at its default width of 64.
// Depends on csa_pkg, csa_if and checked_signed_alu. Requests are queued, driven with random gaps and
// checked against an in-bench predictor.
`timescale 1ns / 100ps

module checked_signed_alu_test;
	import csa_pkg::*;

	localparam int WIDTH = 64;
	localparam int LATENCY = WIDTH + 2;
	localparam longint LIMIT = 400000;
	localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;

	typedef struct {
		logic [4:0]  action;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct {
		logic [63:0] value;
		status_t     status;
	} alu_rsp_t;

	logic clk;
	logic arst_n;

	csa_req_if req ();
	csa_rsp_if rsp ();

	checked_signed_alu #(.WIDTH(WIDTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	alu_req_t pending_reqs[$];
	alu_rsp_t expected_rsps[$];

	int  send_gap_pct;   // chance in percent that the driver idles a cycle
	int  recv_stall_pct; // chance in percent that the monitor holds off
	int  hold_off;       // long receiver hold-off, counted down in its own process
	bit  hold_go;        // asks for the long hold-off
	bit  hold_seen;      // long hold-off already started
	int  mismatches;
	longint cycles = 0;

	// Behavioral predictor of one request.
	function automatic alu_rsp_t alu_predict(alu_req_t r);
		alu_rsp_t res;
		logic signed [63:0] sa, sb;
		logic signed [127:0] wide;
		logic [63:0] v;
		status_t st;
		sa = r.a;
		sb = r.b;
		v = '0;
		st = ST_OK;
		case (r.action)
			OP_ADD: begin
				wide = 128'(sa) + 128'(sb);
				if (wide != 128'(signed'(wide[63:0]))) st = ST_RANGE;
				v = wide[63:0];
			end
			OP_SUB: begin
				wide = 128'(sa) - 128'(sb);
				if (wide != 128'(signed'(wide[63:0]))) st = ST_RANGE;
				v = wide[63:0];
			end
			OP_MUL: begin
				wide = 128'(sa) * 128'(sb);
				if (wide != 128'(signed'(wide[63:0]))) st = ST_RANGE;
				v = wide[63:0];
			end
			OP_DIV, OP_MOD: begin
				if (sb == 0 || (r.a == MINV && sb == -1)) st = ST_RANGE;
				else if (r.action == OP_DIV) v = sa / sb;   // truncates toward zero
				else v = sa % sb;                           // sign of dividend
			end
			OP_SHL, OP_SHR: begin
				if (sb < 0 || sb >= WIDTH) st = ST_RANGE;
				else if (r.action == OP_SHR) v = sa >>> sb[5:0];
				else if (sa < 0 || r.a > (MAXV >> sb[5:0])) st = ST_RANGE;
				else v = r.a << sb[5:0];
			end
			OP_LT:    v = 64'(sa < sb);
			OP_LE:    v = 64'(sa <= sb);
			OP_GT:    v = 64'(sa > sb);
			OP_GE:    v = 64'(sa >= sb);
			OP_EQ:    v = 64'(sa == sb);
			OP_NE:    v = 64'(sa != sb);
			OP_AND:   v = r.a & r.b;
			OP_XOR:   v = r.a ^ r.b;
			OP_OR:    v = r.a | r.b;
			OP_LAND:  v = 64'(sa != 0 && sb != 0);
			OP_LOR:   v = 64'(sa != 0 || sb != 0);
			OP_COMMA: v = r.b;
			default:  st = ST_SYNTAX;
		endcase
		res.value = (st == ST_OK) ? v : '0;
		res.status = st;
		return res;
	endfunction

	// Operand with a bias toward edge values, so overflow checks get hit.
	function automatic logic [63:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MINV;
			1: return MAXV;
			2: return 64'(signed'($urandom_range(0, 20)) - 10);
			3: return 64'($urandom_range(0, 70));
			4: return {{32{1'b0}}, $urandom()};
			5: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	task automatic queue_req(logic [4:0] op, logic [63:0] a, logic [63:0] b);
		alu_req_t r;
		r.action = op;
		r.a = a;
		r.b = b;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Driver: offers the head of the queue; the head is popped once the request is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= '0;
			req.left_operand <= '0;
			req.right_operand <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(alu_predict(alu_req_t'{req.action,
					req.left_operand, req.right_operand}));
				void'(pending_reqs.pop_front());
			end
			// next request: the head after any pop above
			if ((!req.valid || req.ready) ) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					req.valid <= 1'b1;
					req.action <= pending_reqs[0].action;
					req.left_operand <= pending_reqs[0].a;
					req.right_operand <= pending_reqs[0].b;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here and obeyed by the monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off <= 0;
			hold_seen <= 1'b0;
		end else if (hold_go && !hold_seen) begin
			hold_off <= 300;
			hold_seen <= 1'b1;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
		end
	end

	// Monitor: random or long stalls on ready, then compares accepted responses.
	always @(posedge clk or negedge arst_n) begin
		alu_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			mismatches <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsps.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected response value=%h status=%0d",
							rsp.value, rsp.status);
				end else begin
					exp_rsp = expected_rsps.pop_front();
					if (rsp.value !== exp_rsp.value || rsp.status !== exp_rsp.status) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: exp value=%h status=%0d, got value=%h status=%0d",
								exp_rsp.value, exp_rsp.status, rsp.value, rsp.status);
					end
				end
			end
			if (hold_off > 0) begin
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [4:0] op;
		hold_go = 1'b0;
		send_gap_pct = 10;
		recv_stall_pct = 48;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes and each special case.
		queue_req(OP_ADD, MAXV, 64'd1);            // add overflow
		queue_req(OP_SUB, MINV, 64'd1);            // sub overflow
		queue_req(OP_MUL, MINV, -64'sd1);          // mul overflow
		queue_req(OP_MUL, 64'h4000_0000_0000_0000, -64'sd2); // product exactly MIN
		queue_req(OP_DIV, 64'd5, 64'd0);           // divide by zero
		queue_req(OP_MOD, 64'd5, 64'd0);
		queue_req(OP_DIV, MINV, -64'sd1);          // MIN / -1
		queue_req(OP_MOD, MINV, -64'sd1);
		queue_req(OP_DIV, -64'sd7, 64'd2);         // truncation toward zero
		queue_req(OP_MOD, -64'sd7, 64'd2);         // sign of dividend
		queue_req(OP_SHL, 64'd1, -64'sd1);         // negative amount
		queue_req(OP_SHR, 64'd1, 64'd64);          // amount too big
		queue_req(OP_SHL, -64'sd1, 64'd1);         // negative value shifted left
		queue_req(OP_SHL, 64'd1, 64'd63);          // left shift overflow
		queue_req(OP_SHL, 64'd1, 64'd62);
		queue_req(OP_SHR, MINV, 64'd63);           // arithmetic right shift
		for (int i = OP_LT; i <= OP_COMMA; i++)
			queue_req(5'(i), MINV, MAXV);
		queue_req(5'd19, 64'd1, 64'd1);            // unknown codes
		queue_req(5'd31, MAXV, MINV);
		wait_drained();

		// Random, three idling phases; long hold-off in the first one.
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 10 : (phase == 1) ? 48 : 0;
			recv_stall_pct = (phase == 0) ? 48 : (phase == 1) ? 10 : 0;
			for (int i = 0; i < 315; i++) begin
				op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(19, 31))
					: 5'($urandom_range(0, 18));
				queue_req(op, pick_operand(), pick_operand());
				if (phase == 0 && i == 40) hold_go = 1'b1;
			end
			wait_drained();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
